// ===== rtl/bpad_pkg.sv =====
// Package for the Bezier polyline area deviation unit.
// Holds the shared widths and the multiplier request struct.
// No dependencies.
package bpad_pkg;

  localparam int CoordW = 32;
  localparam int AreaW  = 64;

  // Operand request to the shared signed multiplier.
  typedef struct packed {
    logic signed [35:0] a;
    logic signed [35:0] b;
  } mul_req_t;

endpackage

// ===== rtl/bpad_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Computes floor(num / den) for a 47-bit numerator; depends on nothing else.
module bpad_div #(
  parameter int NumW = 47,
  parameter int DenW = 31
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);

  logic [DenW:0]   rem;
  logic [NumW-1:0] sh;
  logic [DenW-1:0] dv;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;
  logic            fits;

  assign trial = {rem[DenW-1:0], sh[NumW-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        rem  <= '0;
        sh   <= num;
        dv   <= den;
        quo  <= '0;
      end else if (busy) begin
        rem <= fits ? trial - {1'b0, dv} : trial;
        sh  <= {sh[NumW-2:0], 1'b0};
        quo <= {quo[NumW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/bezier_polyline_area_deviation_unit.sv =====
// Bezier polyline area deviation unit, top level.
// Uses bpad_pkg and bpad_div.
//
// Usage: program the three control points (index 0..5) and curve_length
// (index 6) through the write port while idle. Then send polyline points
// on the input channel (valid/stall); each beat carries arc_length, point_x,
// point_y and last_point. A beat with last_point set produces one output
// beat with area_total (half the summed triangle areas, Q32.32) and
// area_saturated; other beats produce nothing.
// Processing: the divider first forms t (47 divider steps plus the hand-off), then one
// shared 36x36 signed multiplier runs 3 weight, 6 curve and 2 x 8
// cross-product partial products (17-bit halves into a 128-bit sum).
// A point holds the input stalled until its work is done, so only one point
// is in work at a time; a point that opens a sequence skips the cross products.
// Zero curve_length skips the divider.
// The result sits in an output register; while the receiver stalls it is
// held and new points are still taken; only the next last point waits.
// Reset (rst, synchronous) clears the sequence state and restores the
// registers: control points zero, curve_length 1.0.
module bezier_polyline_area_deviation_unit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [30:0]        arc_length,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        area_total,
  output logic               area_saturated
);
  localparam int F = COORD_FRAC_BITS;
  localparam int NumW = 31 + F;

  // states
  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_W = 4'd2, S_CRV = 4'd3,
                         S_DIF = 4'd4, S_XP = 4'd5, S_ADD = 4'd6, S_FIN = 4'd7;

  logic signed [31:0] sx, sy, mx, my, ex, ey;
  logic [30:0]        clen;

  logic [3:0]  state;
  logic [4:0]  step;
  logic        have_previous, sat_seen;
  logic signed [31:0] prev_curve_x, prev_curve_y, prev_poly_x, prev_poly_y;
  logic [63:0] area_sum;
  logic signed [31:0] px, py, cx, cy;
  logic        lastp;
  logic signed [35:0] t, u, w0, w1, w2;
  logic signed [71:0] acc;
  logic signed [32:0] dax, day, dbx, dby;
  logic signed [127:0] xacc;
  logic [1:0]  tri_n;
  logic        out_free, fin_load;

  // shared multiplier
  bpad_pkg::mul_req_t mreq;
  logic signed [71:0] mprod;
  assign mprod = mreq.a * mreq.b;

  // divider, loaded straight from the input beat at the accepting edge
  logic              dstart, ddone;
  logic [NumW-1:0]   dquo;
  bpad_div #(.NumW(NumW), .DenW(31)) u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .num({arc_length, F'(0)}), .den(clen), .done(ddone), .quo(dquo));

  assign in_stall = (state != S_IDLE);
  assign dstart   = (state == S_IDLE) && in_valid && (clen != '0);

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign fin_load = (state == S_FIN) && lastp && out_free;

  // cross-product partial operands: 33-bit signed split into hi (signed) and
  // low 17-bit unsigned halves
  function automatic logic signed [35:0] part(input logic signed [32:0] v,
                                              input logic hi);
    if (hi) part = 36'(v >>> 17);
    else    part = 36'({1'b0, v[16:0]});
  endfunction

  logic signed [32:0] xa, xb;
  logic signed [35:0] xpa, xpb;
  logic [6:0]         xsh;
  always_comb begin
    // step[2] selects product (a*b or c*d), step[1:0] the partial
    xa = step[2] ? day : dax;
    xb = step[2] ? dbx : dby;
    xpa = part(xa, step[1]);
    xpb = part(xb, step[0]);
    xsh = 7'(17 * (32'(step[1]) + 32'(step[0])));
  end

  // curve coordinate mux
  logic signed [31:0] cc;
  logic signed [35:0] wsel;
  always_comb begin
    case (step[2:0])
      3'd0: cc = sx; 3'd1: cc = mx; 3'd2: cc = ex;
      3'd3: cc = sy; 3'd4: cc = my; default: cc = ey;
    endcase
    case (step[2:0])
      3'd0, 3'd3: wsel = w0;
      3'd1, 3'd4: wsel = w1;
      default:    wsel = w2;
    endcase
    mreq.a = '0;
    mreq.b = '0;
    case (state)
      S_W: begin
        // step 0 forms u; steps 1..3 take u*u, t*u, t*t
        case (step[1:0])
          2'd1:    begin mreq.a = u; mreq.b = u; end
          2'd2:    begin mreq.a = t; mreq.b = u; end
          default: begin mreq.a = t; mreq.b = t; end
        endcase
      end
      S_CRV: begin mreq.a = 36'(cc); mreq.b = wsel; end
      S_XP:  begin mreq.a = xpa; mreq.b = xpb; end
      default: ;
    endcase
  end

  // curve coordinate from the running sum plus this cycle's product
  logic signed [71:0] csh;
  logic signed [31:0] csat;
  logic               cov;
  always_comb begin
    csh = (acc + mprod) >>> F;
    cov = (csh > 72'sd2147483647) || (csh < -72'sd2147483648);
    if (csh > 72'sd2147483647)       csat = 32'sh7fffffff;
    else if (csh < -72'sd2147483648) csat = 32'sh80000000;
    else                             csat = csh[31:0];
  end

  logic [127:0] xabs;
  logic [64:0]  asum;
  assign xabs = xacc[127] ? 128'(-xacc) : 128'(xacc);
  assign asum = {1'b0, area_sum} + {1'b0, xabs[63:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0; sy <= '0; mx <= '0; my <= '0; ex <= '0; ey <= '0;
      clen <= 31'(64'd1 << F);
      state <= S_IDLE;
      step <= '0;
      have_previous <= 1'b0;
      sat_seen <= 1'b0;
      area_sum <= '0;
      prev_curve_x <= '0; prev_curve_y <= '0;
      prev_poly_x <= '0; prev_poly_y <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          3'd0: sx <= cfg_data;
          3'd1: sy <= cfg_data;
          3'd2: mx <= cfg_data;
          3'd3: my <= cfg_data;
          3'd4: ex <= cfg_data;
          3'd5: ey <= cfg_data;
          3'd6: clen <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (fin_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            px <= point_x; py <= point_y; lastp <= last_point;
            if (clen == '0) begin
              t <= 36'(64'd4 << F);
              sat_seen <= 1'b1;
              state <= S_W;
            end else begin
              state <= S_DIV;
            end
            step <= '0;
          end
        end
        S_DIV: begin
          if (ddone) begin
            if (dquo > NumW'(64'd4 << F)) begin
              t <= 36'(64'd4 << F);
              sat_seen <= 1'b1;
            end else begin
              t <= 36'(dquo);
            end
            state <= S_W;
          end
        end
        S_W: begin
          // step 0 forms u, steps 1..3 weights
          case (step[1:0])
            2'd0:    u <= 36'(64'd1 << F) - t;
            2'd1:    w0 <= 36'(mprod >>> F);
            2'd2:    w1 <= 36'(mprod >>> (F - 1));
            default: w2 <= 36'(mprod >>> F);
          endcase
          if (step == 5'd3) begin
            step <= '0;
            acc <= '0;
            state <= S_CRV;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_CRV: begin
          // three products per coordinate; the third closes x or y
          if (step == 5'd2 || step == 5'd5) begin
            acc <= '0;
            if (cov) sat_seen <= 1'b1;
          end else begin
            acc <= acc + mprod;
          end
          if (step == 5'd2) cx <= csat;
          if (step == 5'd5) cy <= csat;
          if (step == 5'd5) begin
            step <= '0;
            tri_n <= '0;
            state <= have_previous ? S_DIF : S_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIF: begin
          if (tri_n == 2'd0) begin
            dax <= 33'(prev_curve_x) - 33'(cx);
            day <= 33'(prev_curve_y) - 33'(cy);
            dbx <= 33'(prev_curve_x) - 33'(prev_poly_x);
            dby <= 33'(prev_curve_y) - 33'(prev_poly_y);
          end else begin
            dax <= 33'(px) - 33'(prev_poly_x);
            day <= 33'(py) - 33'(prev_poly_y);
            dbx <= 33'(cx) - 33'(px);
            dby <= 33'(cy) - 33'(py);
          end
          xacc <= '0;
          step <= '0;
          state <= S_XP;
        end
        S_XP: begin
          if (step[2]) xacc <= xacc - (128'(mprod) <<< xsh);
          else         xacc <= xacc + (128'(mprod) <<< xsh);
          step <= step + 1'b1;
          if (step == 5'd7) state <= S_ADD;
        end
        S_ADD: begin
          if (xabs[127:64] != '0 || asum[64]) begin
            area_sum <= '1;
            sat_seen <= 1'b1;
          end else begin
            area_sum <= asum[63:0];
          end
          tri_n <= tri_n + 1'b1;
          state <= (tri_n == 2'd0) ? S_DIF : S_FIN;
        end
        S_FIN: begin
          if (!lastp) begin
            have_previous <= 1'b1;
            prev_curve_x <= cx; prev_curve_y <= cy;
            prev_poly_x <= px; prev_poly_y <= py;
            state <= S_IDLE;
          end else if (out_free) begin
            // wait here while an earlier result is still stalled
            area_total <= (area_sum == '1) ? '1 : (area_sum >> 1);
            area_saturated <= sat_seen;
            have_previous <= 1'b0;
            prev_curve_x <= '0; prev_curve_y <= '0;
            prev_poly_x <= '0; prev_poly_y <= '0;
            area_sum <= '0;
            sat_seen <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/bpad_check.sv =====
// Port-level checker for the Bezier polyline area deviation unit.
// Bound to the top level; depends on nothing else.
module bpad_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] area_total
);
  // one point in work at a time: an accepted beat stalls the input next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("input not stalled");
  // a result is only loaded from a point in work, never from idle
  a_load: assert property (@(posedge clk) disable iff (rst)
    !in_stall |=> !$rose(out_valid)) else $error("result without a point in work");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(area_total)))
    else $error("stalled result changed");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind bezier_polyline_area_deviation_unit bpad_check u_bpad_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .area_total(area_total));

// ===== bench/bpad_checker.sv =====
// Checker for the Bezier polyline area deviation unit: tracks register
// writes, predicts the area result of every sequence and compares each beat.
// Uses bpad_pkg for widths; needs nothing else.
module bpad_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [30:0]        arc_length,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic               last_point,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [63:0]        area_total,
  input  logic               area_saturated,
  output int                 errors,
  output int                 pending,
  output int                 results
);
  localparam int FracBits = 16;
  localparam longint One  = longint'(1) << FracBits;
  localparam longint TMax = longint'(4) << FracBits;

  typedef enum logic [2:0] {
    RegStartX, RegStartY, RegMidX, RegMidY, RegEndX, RegEndY, RegLength
  } reg_idx_e;

  typedef struct {
    logic [bpad_pkg::AreaW-1:0] area;
    logic                       sat;
  } area_beat_t;

  area_beat_t area_q[$];

  logic signed [bpad_pkg::CoordW-1:0] ctrl_pt[6];
  logic [30:0]                        curve_len;
  logic                               seq_open, seq_sat;
  longint                             last_cx, last_cy, last_px, last_py;
  logic [bpad_pkg::AreaW-1:0]         seq_area;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin seq_sat = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin seq_sat = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic logic [63:0] abs_cross(input longint ax, input longint ay,
                                            input longint bx, input longint by);
    logic signed [127:0] p;
    p = 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
    if (p < 0) p = -p;
    if (p[127:64] != 0) begin seq_sat = 1; return '1; end
    return p[63:0];
  endfunction

  function automatic void add_area(input logic [63:0] v);
    logic [64:0] s;
    s = {1'b0, seq_area} + {1'b0, v};
    if (s[64]) begin seq_sat = 1; seq_area = '1; end
    else seq_area = s[63:0];
  endfunction

  function automatic void clear_seq();
    seq_open = 0; seq_sat = 0; seq_area = 0;
    last_cx = 0; last_cy = 0; last_px = 0; last_py = 0;
  endfunction

  // one polyline point: curve point at t, then the two triangle terms
  task automatic predict_point(input logic [30:0] arc, input longint px, input longint py,
                               input logic fin);
    longint t, u, w0, w1, w2, cx, cy;
    logic [63:0] tq;
    area_beat_t b;
    if (curve_len == 0) begin
      tq = TMax; seq_sat = 1;
    end else begin
      tq = ({33'b0, arc} << FracBits) / curve_len;
      if (tq > TMax) begin tq = TMax; seq_sat = 1; end
    end
    t  = longint'(tq);
    u  = One - t;
    w0 = (u * u) >>> FracBits;
    w1 = (2 * t * u) >>> FracBits;
    w2 = (t * t) >>> FracBits;
    cx = clamp32((longint'(ctrl_pt[RegStartX]) * w0 + longint'(ctrl_pt[RegMidX]) * w1
                  + longint'(ctrl_pt[RegEndX]) * w2) >>> FracBits);
    cy = clamp32((longint'(ctrl_pt[RegStartY]) * w0 + longint'(ctrl_pt[RegMidY]) * w1
                  + longint'(ctrl_pt[RegEndY]) * w2) >>> FracBits);
    if (seq_open) begin
      add_area(abs_cross(last_cx - cx, last_cy - cy, last_cx - last_px, last_cy - last_py));
      add_area(abs_cross(px - last_px, py - last_py, cx - px, cy - py));
    end
    seq_open = 1;
    last_cx = cx; last_cy = cy; last_px = px; last_py = py;
    if (fin) begin
      b.area = (seq_area == '1) ? '1 : (seq_area >> 1);
      b.sat  = seq_sat;
      area_q.push_back(b);
      clear_seq();
    end
  endtask

  always @(posedge clk) begin
    area_beat_t w;
    if (rst) begin
      foreach (ctrl_pt[i]) ctrl_pt[i] = 0;
      curve_len = 31'(One);
      clear_seq();
      area_q.delete();
      errors  = 0;
      results = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results++;
        if (area_q.size() == 0) begin
          report("unexpected beat", area_total, 0);
        end else begin
          w = area_q.pop_front();
          if (area_total !== w.area) report("area_total", area_total, w.area);
          if (area_saturated !== w.sat) report("area_saturated", area_saturated, w.sat);
        end
      end
      if (in_valid && !in_stall)
        predict_point(arc_length, longint'(point_x), longint'(point_y), last_point);
      if (cfg_we) begin
        if (cfg_index == RegLength) curve_len = cfg_data[30:0];
        else if (cfg_index < RegLength) ctrl_pt[cfg_index] = cfg_data;
      end
    end
    pending = area_q.size();
  end
endmodule

// ===== bench/tb_top.sv =====
// Top of the bench for bezier_polyline_area_deviation_unit: clock, reset,
// register phases, point stimulus with random gaps and output stalls.
// Depends on the block and bpad_checker.
module tb_top;
  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = 0;
  logic [31:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [30:0]        arc_length = 0;
  logic signed [31:0] point_x = 0;
  logic signed [31:0] point_y = 0;
  logic               last_point = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [63:0]        area_total;
  logic               area_saturated;

  int errors, pending, results;
  int points_sent;
  int stall_left;
  bit calm;        // when set, neither side idles

  localparam int RegLength = 6;
  localparam int RegUnused = 7;
  localparam int DrainCycles = 150;

  always #4 clk = ~clk;

  bezier_polyline_area_deviation_unit i_dut (.*);

  bpad_checker i_checker (.*);

  // Receiver: after each taken beat, stall for a random number of cycles.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) stall_left = calm ? 0 : $urandom_range(0, 19);

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // One point beat. Valid stays high straight into the next beat on a zero gap.
  task automatic send_point(input logic [30:0] arc, input logic [31:0] x, input logic [31:0] y,
                            input logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1;
    arc_length <= arc;
    point_x    <= x;
    point_y    <= y;
    last_point <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    points_sent++;
  endtask

  // Wait until all results are in plus the block's own latency.
  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Program all registers back to back; idx 7 is unused and must be ignored.
  task automatic program_curve(input logic [31:0] pts[6], input logic [30:0] len,
                               input bit poke_unused);
    cfg_we <= 1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= 3'(i);
      cfg_data  <= pts[i];
      @(negedge clk);
    end
    cfg_index <= 3'(RegLength);
    cfg_data  <= {1'b0, len};
    @(negedge clk);
    if (poke_unused) begin
      cfg_index <= 3'(RegUnused);
      cfg_data  <= $urandom;
      @(negedge clk);
    end
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input bit wide);
    logic [31:0] c;
    c = $urandom;
    if (wide) return c;
    return {{12{c[19]}}, c[19:0]};
  endfunction

  // Random sequences: mostly t in range, some past four, some full-range arcs.
  task automatic run_sequences(input int n_points, input logic [30:0] len, input bit wide);
    int left, seq_len;
    logic [30:0] arc;
    left = n_points;
    while (left > 0) begin
      seq_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
      for (int k = 0; k < seq_len && left > 0; k++) begin
        case ($urandom_range(0, 9))
          0: arc = 31'($urandom);
          1: arc = '1;
          default: begin
            longint lim;
            lim = longint'(len) * 5;
            if (lim > 64'h7fffffff) lim = 64'h7fffffff;
            arc = 31'(longint'($urandom) % (lim + 1));
          end
        endcase
        send_point(arc, rand_coord(wide || $urandom_range(0, 7) == 0),
                   rand_coord(wide || $urandom_range(0, 7) == 0),
                   (k == seq_len - 1) || left == 1);
        left--;
      end
    end
  endtask

  logic [31:0] pts[6];
  logic [30:0] len;

  initial begin
    points_sent = 0;
    stall_left  = 0;
    calm        = 0;
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed, reset registers: curve collapsed at origin, length 1.0.
    send_point(0, 32'h7fffffff, 32'h80000000, 1);               // lone point
    send_point(0, 0, 0, 0);
    send_point(31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);    // t clamps at four
    send_point(31'h00010000, 32'h80000000, 32'h80000000, 1);
    drain();

    // Extreme control points: curve coordinates and sums saturate.
    pts = '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
            32'h7fffffff, 32'h80000000};
    program_curve(pts, 31'd1, 1);
    send_point(0, 32'h80000000, 32'h7fffffff, 0);
    send_point(31'd1, 32'h7fffffff, 32'h80000000, 0);
    send_point(31'h7fffffff, 32'h80000000, 32'h80000000, 1);
    drain();
    program_curve(pts, 31'h7fffffff, 0);
    send_point(0, 32'h7fffffff, 32'h7fffffff, 0);
    send_point(31'h3fffffff, 32'h80000000, 32'h80000000, 0);
    send_point(31'h7fffffff, 32'h7fffffff, 32'h80000000, 1);
    drain();

    // Zero length: t taken as four.
    pts = '{32'h00010000, 32'hffff0000, 32'h00030000, 32'h00020000,
            32'hfffe0000, 32'h00050000};
    program_curve(pts, 31'd0, 0);
    send_point(31'h00008000, 32'h00001000, 32'h00002000, 0);
    send_point(31'h00010000, 32'hffff1000, 32'h00012000, 1);
    drain();

    // Random phases with fresh curves; the second stays fully calm.
    for (int ph = 0; ph < 10; ph++) begin
      bit wide;
      wide = (ph == 4 || ph == 8);
      foreach (pts[i]) pts[i] = rand_coord(wide);
      case (ph)
        2: len = 31'd1;
        5: len = 31'h7fffffff;
        7: len = 31'd0;
        default: len = 31'($urandom_range(1, 32'h00400000));
      endcase
      calm = (ph == 1);
      program_curve(pts, len, ph == 3);
      run_sequences(93, len, wide);
      drain();    // sender holds until every result is back
    end
    calm = 0;
    drain();

    $display("covered %0d points, %0d area results over directed and random curves",
             points_sent, results);
    if (errors == 0) begin
      $display("PASS bezier_polyline_area_deviation_unit");
    end else begin
      $display("FAIL bezier_polyline_area_deviation_unit");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL bezier_polyline_area_deviation_unit");
    $finish;
  end
endmodule
